>>> rtl/flow_potential_complete_graph_defines.svh
// Assertion macros shared by the flow potential RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef FLOW_POTENTIAL_COMPLETE_GRAPH_DEFINES_SVH
`define FLOW_POTENTIAL_COMPLETE_GRAPH_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FPCG_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("flow potential check failed");
`define FPCG_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("flow potential check failed");
`else
`define FPCG_ASSERT_IMPL(name, ante, cons)
`define FPCG_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> rtl/fpcg_pkg.sv
// Types and fixed widths for the flow potential block.
// No dependencies; used by the top level.
package fpcg_pkg;

    localparam int ZONE_W    = 5;
    localparam int CFG_W     = 6;
    localparam int COUNT_W   = 16;
    localparam int CELL_W    = 32;
    localparam logic [CELL_W-1:0] CELL_MAX = 32'h7FFF_FFFF;

    // sized for up to 64 zones
    localparam int ROW_W     = 38;
    localparam int HALF_W    = 19;
    localparam int SQ_W      = 64;
    localparam int S2_W      = 74;
    localparam int R_W       = 84;
    localparam int DIV_W     = 108;
    localparam int CNT_W     = 7;
    localparam int POT_W     = 54;
    localparam int SQ_IN_W   = 96;
    localparam int SQ_RES_W  = 48;
    localparam int SQR_W     = 50;
    localparam int FIT_W     = 23;
    localparam int DEV_W     = 44;
    localparam int POT_OUT_W = 48;
    localparam logic [FIT_W-1:0] FIT_MAX = 23'd6553600;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC_UPD,
        ST_REC_MIR,
        ST_SWEEP,
        ST_DRAIN,
        ST_SUMR,
        ST_PREP,
        ST_FIT_LD,
        ST_FIT_DIV,
        ST_DEV_DIV,
        ST_SQRT,
        ST_POT_RD,
        ST_POT_LD,
        ST_POT_DIV,
        ST_POT_OUT
    } state_t;

    typedef enum logic [2:0] {
        SR_READ,
        SR_LATCH,
        SR_LO,
        SR_MID,
        SR_HI,
        SR_ACC
    } sumr_step_t;

    typedef enum logic [1:0] {
        PSH_0,
        PSH_20,
        PSH_38
    } prod_shift_t;

endpackage

>>> rtl/fpcg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
module fpcg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

>>> rtl/flow_potential_complete_graph.sv
// Flow potential top level: net-flow matrix in RAM, row sums, fit and deviation.
// Depends on fpcg_pkg, fpcg_ram and flow_potential_complete_graph_defines.svh.
//
// channel   dir  handshake                payload
// s_        in   s_valid / s_ready        operation, origin, dest, trip count
// m_        out  m_valid / m_ready        zone, potential, fit, deviation, flags
// cfg_      in   cfg_valid / cfg_ready    zone_count
//
// A trip record is read, then written; its mirror write overlaps the next accept; an
// ignored record is dropped. Finish sweeps all MAX_ZONES^2 entries (read and clear),
// then forms squared row sums zone by zone and, unless there is no flow, two
// divisions and a square root, then one potential division per zone.
// After reset a clearing pass over all MAX_ZONES^2 entries holds s_ready low.
// The output register lets a new item be accepted while the last result waits.
`include "flow_potential_complete_graph_defines.svh"

module flow_potential_complete_graph
    import fpcg_pkg::*;
#(
    parameter int MAX_ZONES = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [ZONE_W-1:0]     s_origin_index,
    input  logic [ZONE_W-1:0]     s_dest_index,
    input  logic [COUNT_W-1:0]    s_trip_count,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ZONE_W-1:0]     m_zone_index,
    output logic signed [POT_OUT_W-1:0] m_potential_q16,
    output logic [FIT_W-1:0]      m_fit_percent_q16,
    output logic [DEV_W-1:0]      m_null_deviation_q8,
    output logic                  m_no_flow,
    output logic                  m_last,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_zone_count
);

    localparam int IW    = $clog2(MAX_ZONES);
    localparam int NW    = $clog2(MAX_ZONES + 1);
    localparam int AW    = $clog2(MAX_ZONES * MAX_ZONES);
    localparam int NN_W  = 2 * NW;
    localparam int N3_W  = 3 * NW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ZONES * MAX_ZONES - 1);
    localparam logic [IW-1:0] LAST_J    = IW'(MAX_ZONES - 1);
    localparam logic [NW-1:0] ZC_RESET  = NW'((32 > MAX_ZONES) ? MAX_ZONES : 32);

    state_t state_reg, state_next;
    logic [NW-1:0] zone_count_reg;
    logic [NW-1:0] cfg_n;

    // matrix RAM ports
    logic              mat_wr_en;
    logic [AW-1:0]     mat_wr_addr, mat_rd_addr;
    logic [CELL_W-1:0] mat_wr_data, mat_rd_data;
    // row-sum RAM ports
    logic              row_wr_en;
    logic [IW-1:0]     row_rd_addr;
    logic [ROW_W-1:0]  row_wr_data, row_rd_data;

    // record path
    logic              rec_ok;
    logic [AW-1:0]     rec_addr, mir_addr;
    logic [AW-1:0]     rec_addr_reg, mir_addr_reg;
    logic [COUNT_W-1:0] rec_cnt_reg;
    logic [CELL_W-1:0] v_reg, upd_val, cur_val, fwd_data_reg;
    logic              fwd_reg;
    logic signed [CELL_W:0] sum_ext;

    // sweep pipeline
    logic [AW-1:0]     sw_addr_reg;
    logic [IW-1:0]     sw_i_reg, sw_j_reg;
    logic              p1_valid_reg, p1_use_reg, p1_first_reg, p1_lastj_reg;
    logic [IW-1:0]     p1_i_reg;
    logic signed [CELL_W-1:0] y_val;
    logic [CELL_W-1:0] y_mag;
    logic signed [ROW_W-1:0] row_acc_reg, row_acc_next;
    logic [SQ_W-1:0]   sq_reg;
    logic              sq_valid_reg;
    logic [S2_W-1:0]   s2_reg;

    // row squares
    logic [IW-1:0]     zi_reg;
    logic              zi_last;
    sumr_step_t        k_reg;
    logic [ROW_W-1:0]  mag_reg, row_mag;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [2*HALF_W-1:0] prod_reg;
    prod_shift_t       sh_reg;
    logic [R_W-1:0]    prod_sh, r_acc_reg;

    // scalars for fit and deviation
    logic [DIV_W-1:0]  numer_reg, denom_reg;
    logic [NN_W-1:0]   nn_reg;
    logic [N3_W-1:0]   n3_reg;
    logic [FIT_W-1:0]  fit_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic              none_reg;

    // shared divider
    logic [DIV_W-1:0]  dv_num_reg, dv_den_reg, dv_rem_reg, dv_quo_reg, dv_rem_new;
    logic [CNT_W-1:0]  dv_cnt_reg;
    logic [DIV_W:0]    dv_rem_sh;
    logic              dv_ge;

    // square root
    logic [SQ_IN_W-1:0]  sq_op_reg;
    logic [SQR_W-1:0]    sq_rem_reg;
    logic [SQ_RES_W-1:0] sq_res_reg;
    logic [SQR_W+1:0]    sq_rem_sh, sq_trial;
    logic                sq_ge;

    // potential
    logic              pot_neg_reg;
    logic [POT_W-1:0]  pot_dividend;
    logic              out_slot;

    // output register
    logic              m_valid_reg, m_no_flow_reg, m_last_reg;
    logic [ZONE_W-1:0] m_zone_index_reg;
    logic [POT_OUT_W-1:0] m_potential_reg;
    logic [FIT_W-1:0]  m_fit_reg;
    logic [DEV_W-1:0]  m_dev_reg;

    fpcg_ram #(.WIDTH(CELL_W), .DEPTH(MAX_ZONES * MAX_ZONES)) u_mat_ram (
        .aclk    (aclk),
        .wr_en   (mat_wr_en),
        .wr_addr (mat_wr_addr),
        .wr_data (mat_wr_data),
        .rd_addr (mat_rd_addr),
        .rd_data (mat_rd_data)
    );

    fpcg_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ZONES)) u_row_ram (
        .aclk    (aclk),
        .wr_en   (row_wr_en),
        .wr_addr (p1_i_reg),
        .wr_data (row_wr_data),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_zone_count == '0) begin
            cfg_n = NW'(1);
        end else if (32'(cfg_zone_count) > MAX_ZONES) begin
            cfg_n = NW'(MAX_ZONES);
        end else begin
            cfg_n = NW'(cfg_zone_count);
        end
    end

    assign rec_ok   = (32'(s_origin_index) < 32'(zone_count_reg)) &&
                      (32'(s_dest_index) < 32'(zone_count_reg)) &&
                      (s_origin_index != s_dest_index);
    assign rec_addr = AW'(32'(s_origin_index) * MAX_ZONES + 32'(s_dest_index));
    assign mir_addr = AW'(32'(s_dest_index) * MAX_ZONES + 32'(s_origin_index));

    // read-modify-write: forward the mirror write when the next record hits it
    assign cur_val = fwd_reg ? fwd_data_reg : mat_rd_data;
    assign sum_ext = $signed({cur_val[CELL_W-1], cur_val}) + $signed({1'b0, 17'(rec_cnt_reg)});
    assign upd_val = (sum_ext > $signed({1'b0, CELL_MAX})) ? CELL_MAX : sum_ext[CELL_W-1:0];

    // sweep datapath
    assign y_val        = p1_use_reg ? $signed(mat_rd_data) : '0;
    assign y_mag        = y_val[CELL_W-1] ? (~y_val + 32'd1) : y_val;
    assign row_acc_next = (p1_first_reg ? '0 : row_acc_reg) + ROW_W'(y_val);
    assign row_wr_en    = p1_valid_reg && p1_lastj_reg;
    assign row_wr_data  = row_acc_next;

    assign row_mag = row_rd_data[ROW_W-1] ? (~row_rd_data + ROW_W'(1)) : row_rd_data;
    assign zi_last = (32'(zi_reg) + 32'd1) == 32'(zone_count_reg);

    always_comb begin
        case (k_reg)
            SR_LO: begin
                mul_a = mag_reg[HALF_W-1:0];
                mul_b = mag_reg[HALF_W-1:0];
            end
            SR_MID: begin
                mul_a = mag_reg[ROW_W-1:HALF_W];
                mul_b = mag_reg[HALF_W-1:0];
            end
            default: begin
                mul_a = mag_reg[ROW_W-1:HALF_W];
                mul_b = mag_reg[ROW_W-1:HALF_W];
            end
        endcase
        case (sh_reg)
            PSH_0:   prod_sh = R_W'(prod_reg);
            PSH_20:  prod_sh = R_W'(prod_reg) << 20;
            PSH_38:  prod_sh = R_W'(prod_reg) << 38;
            default: prod_sh = '0;
        endcase
    end

    // restoring divider step
    assign dv_rem_sh  = {dv_rem_reg, dv_num_reg[DIV_W-1]};
    assign dv_ge      = dv_rem_sh >= {1'b0, dv_den_reg};
    assign dv_rem_new = dv_ge ? DIV_W'(dv_rem_sh - {1'b0, dv_den_reg}) : DIV_W'(dv_rem_sh);

    // digit-by-digit square root step
    assign sq_rem_sh = {sq_rem_reg, sq_op_reg[SQ_IN_W-1 -: 2]};
    assign sq_trial  = (SQR_W + 2)'({sq_res_reg, 2'b01});
    assign sq_ge     = sq_rem_sh >= sq_trial;

    assign pot_dividend = {row_mag, 16'b0} + POT_W'(zone_count_reg >> 1);
    assign out_slot     = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        mat_wr_en   = 1'b0;
        mat_wr_addr = sw_addr_reg;
        mat_wr_data = '0;
        mat_rd_addr = sw_addr_reg;
        row_rd_addr = zi_reg;
        case (state_reg)
            ST_CLEAR: begin
                mat_wr_en = 1'b1;
                if (sw_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE, ST_REC_MIR: begin
                s_ready = 1'b1;
                if (state_reg == ST_REC_MIR) begin
                    mat_wr_en   = 1'b1;
                    mat_wr_addr = mir_addr_reg;
                    mat_wr_data = ~v_reg + 32'd1;
                end
                mat_rd_addr = rec_addr;
                if (s_valid) begin
                    if (s_operation == OP_FINISH) begin
                        state_next = ST_SWEEP;
                    end else if (rec_ok) begin
                        state_next = ST_REC_UPD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_REC_UPD: begin
                mat_wr_en   = 1'b1;
                mat_wr_addr = rec_addr_reg;
                mat_wr_data = upd_val;
                state_next  = ST_REC_MIR;
            end
            ST_SWEEP: begin
                // read and clear in the same cycle
                mat_wr_en = 1'b1;
                if (sw_addr_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_SUMR;
            ST_SUMR: begin
                if (k_reg == SR_ACC && zi_last) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = (s2_reg == '0) ? ST_POT_RD : ST_FIT_LD;
            ST_FIT_LD: state_next = ST_FIT_DIV;
            ST_FIT_DIV: begin
                if (dv_cnt_reg == '0) begin
                    state_next = ST_DEV_DIV;
                end
            end
            ST_DEV_DIV: begin
                if (dv_cnt_reg == '0) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (dv_cnt_reg == '0) begin
                    state_next = ST_POT_RD;
                end
            end
            ST_POT_RD: state_next = ST_POT_LD;
            ST_POT_LD: state_next = ST_POT_DIV;
            ST_POT_DIV: begin
                if (dv_cnt_reg == '0) begin
                    state_next = ST_POT_OUT;
                end
            end
            ST_POT_OUT: begin
                if (out_slot) begin
                    state_next = zi_last ? ST_IDLE : ST_POT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            zone_count_reg <= ZC_RESET;
            sw_addr_reg    <= '0;
            p1_valid_reg   <= 1'b0;
            sq_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            fwd_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                zone_count_reg <= cfg_n;
            end
            sq_valid_reg <= p1_valid_reg;
            p1_valid_reg <= (state_reg == ST_SWEEP);
            if ((state_reg == ST_IDLE || state_reg == ST_REC_MIR) && s_valid) begin
                sw_addr_reg <= '0;
                fwd_reg     <= (state_reg == ST_REC_MIR) && (rec_addr == mir_addr_reg);
            end else if (state_reg == ST_CLEAR || state_reg == ST_SWEEP) begin
                sw_addr_reg <= sw_addr_reg + AW'(1);
            end
            if (state_reg == ST_POT_OUT && out_slot) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        nn_reg    <= NN_W'(zone_count_reg) * NN_W'(zone_count_reg);
        n3_reg    <= N3_W'(nn_reg) * N3_W'(zone_count_reg);
        denom_reg <= DIV_W'(s2_reg[S2_W-1:1]) * DIV_W'(zone_count_reg);
        // 6553600 = (64 + 32 + 4) << 16
        numer_reg <= (DIV_W'(r_acc_reg) << 22) + (DIV_W'(r_acc_reg) << 21) +
                     (DIV_W'(r_acc_reg) << 18);

        // sweep pipeline, stage one
        p1_use_reg   <= (32'(sw_i_reg) < 32'(zone_count_reg)) &&
                        (32'(sw_j_reg) < 32'(zone_count_reg));
        p1_first_reg <= (sw_j_reg == '0);
        p1_lastj_reg <= (sw_j_reg == LAST_J);
        p1_i_reg     <= sw_i_reg;
        // stage two
        if (p1_valid_reg) begin
            row_acc_reg <= row_acc_next;
            sq_reg      <= SQ_W'(y_mag) * SQ_W'(y_mag);
        end
        // stage three: every entry squared, which is twice the upper triangle
        if (sq_valid_reg) begin
            s2_reg <= s2_reg + S2_W'(sq_reg);
        end

        case (state_reg)
            ST_IDLE, ST_REC_MIR: begin
                rec_addr_reg <= rec_addr;
                mir_addr_reg <= mir_addr;
                rec_cnt_reg  <= s_trip_count;
                fwd_data_reg <= ~v_reg + 32'd1;
                sw_i_reg     <= '0;
                sw_j_reg     <= '0;
                if (s_valid && s_operation == OP_FINISH) begin
                    s2_reg    <= '0;
                    r_acc_reg <= '0;
                end
            end
            ST_REC_UPD: v_reg <= upd_val;
            ST_SWEEP: begin
                if (sw_j_reg == LAST_J) begin
                    sw_j_reg <= '0;
                    sw_i_reg <= sw_i_reg + IW'(1);
                end else begin
                    sw_j_reg <= sw_j_reg + IW'(1);
                end
            end
            ST_DRAIN: begin
                zi_reg <= '0;
                k_reg  <= SR_READ;
            end
            ST_SUMR: begin
                case (k_reg)
                    SR_READ:  k_reg <= SR_LATCH;
                    SR_LATCH: begin
                        mag_reg <= row_mag;
                        k_reg   <= SR_LO;
                    end
                    SR_LO: begin
                        prod_reg <= mul_a * mul_b;
                        sh_reg   <= PSH_0;
                        k_reg    <= SR_MID;
                    end
                    SR_MID: begin
                        r_acc_reg <= r_acc_reg + prod_sh;
                        prod_reg  <= mul_a * mul_b;
                        sh_reg    <= PSH_20;
                        k_reg     <= SR_HI;
                    end
                    SR_HI: begin
                        r_acc_reg <= r_acc_reg + prod_sh;
                        prod_reg  <= mul_a * mul_b;
                        sh_reg    <= PSH_38;
                        k_reg     <= SR_ACC;
                    end
                    SR_ACC: begin
                        r_acc_reg <= r_acc_reg + prod_sh;
                        zi_reg    <= zi_reg + IW'(1);
                        k_reg     <= SR_READ;
                    end
                    default: k_reg <= SR_READ;
                endcase
            end
            ST_PREP: begin
                zi_reg   <= '0;
                none_reg <= (s2_reg == '0);
                fit_reg  <= '0;
                dev_reg  <= '0;
            end
            ST_FIT_LD: begin
                dv_num_reg <= numer_reg;
                dv_den_reg <= denom_reg;
                dv_rem_reg <= '0;
                dv_quo_reg <= '0;
                dv_cnt_reg <= CNT_W'(DIV_W);
            end
            ST_FIT_DIV, ST_DEV_DIV, ST_POT_DIV: begin
                if (dv_cnt_reg != '0) begin
                    dv_num_reg <= dv_num_reg << 1;
                    dv_rem_reg <= dv_rem_new;
                    dv_quo_reg <= {dv_quo_reg[DIV_W-2:0], dv_ge};
                    dv_cnt_reg <= dv_cnt_reg - CNT_W'(1);
                end else if (state_reg == ST_FIT_DIV) begin
                    fit_reg    <= (dv_quo_reg > DIV_W'(FIT_MAX)) ? FIT_MAX :
                                  dv_quo_reg[FIT_W-1:0];
                    // 2 * sumsq * 2^16 is the full square sum shifted by 16
                    dv_num_reg <= DIV_W'(s2_reg) << 16;
                    dv_den_reg <= DIV_W'(n3_reg);
                    dv_rem_reg <= '0;
                    dv_quo_reg <= '0;
                    dv_cnt_reg <= CNT_W'(DIV_W);
                end else if (state_reg == ST_DEV_DIV) begin
                    sq_op_reg  <= dv_quo_reg[SQ_IN_W-1:0];
                    sq_rem_reg <= '0;
                    sq_res_reg <= '0;
                    dv_cnt_reg <= CNT_W'(SQ_RES_W);
                end
            end
            ST_SQRT: begin
                if (dv_cnt_reg != '0) begin
                    sq_op_reg  <= sq_op_reg << 2;
                    sq_rem_reg <= sq_ge ? SQR_W'(sq_rem_sh - sq_trial) : SQR_W'(sq_rem_sh);
                    sq_res_reg <= {sq_res_reg[SQ_RES_W-2:0], sq_ge};
                    dv_cnt_reg <= dv_cnt_reg - CNT_W'(1);
                end else begin
                    dev_reg <= sq_res_reg[DEV_W-1:0];
                    zi_reg  <= '0;
                end
            end
            ST_POT_LD: begin
                pot_neg_reg <= !row_rd_data[ROW_W-1] && (row_rd_data != '0);
                dv_num_reg  <= {pot_dividend, (DIV_W - POT_W)'(0)};
                dv_den_reg  <= DIV_W'(zone_count_reg);
                dv_rem_reg  <= '0;
                dv_quo_reg  <= '0;
                dv_cnt_reg  <= CNT_W'(POT_W);
            end
            ST_POT_OUT: begin
                if (out_slot) begin
                    m_zone_index_reg <= ZONE_W'(zi_reg);
                    m_potential_reg  <= pot_neg_reg ?
                                        (~dv_quo_reg[POT_OUT_W-1:0] + POT_OUT_W'(1)) :
                                        dv_quo_reg[POT_OUT_W-1:0];
                    m_fit_reg        <= fit_reg;
                    m_dev_reg        <= dev_reg;
                    m_no_flow_reg    <= none_reg;
                    m_last_reg       <= zi_last;
                    zi_reg           <= zi_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_valid             = m_valid_reg;
    assign m_zone_index        = m_zone_index_reg;
    assign m_potential_q16     = m_potential_reg;
    assign m_fit_percent_q16   = m_fit_reg;
    assign m_null_deviation_q8 = m_dev_reg;
    assign m_no_flow           = m_no_flow_reg;
    assign m_last              = m_last_reg;

    `FPCG_ASSERT_IMPL(a_mirror_negates, state_reg == ST_REC_MIR,
        mat_wr_data == (~$past(mat_wr_data) + 32'd1))
    `FPCG_ASSERT_IMPL(a_zone_count_range, 1'b1,
        zone_count_reg != '0 && 32'(zone_count_reg) <= MAX_ZONES)
    `FPCG_ASSERT_IMPL(a_fit_bound, m_valid, m_fit_percent_q16 <= FIT_MAX)
    `FPCG_ASSERT_IMPL(a_no_flow_zero, m_valid && m_no_flow,
        m_fit_percent_q16 == '0 && m_null_deviation_q8 == '0)
    `FPCG_ASSERT_IMPL(a_div_remainder,
        state_reg == ST_FIT_DIV || state_reg == ST_DEV_DIV || state_reg == ST_POT_DIV,
        dv_rem_reg < dv_den_reg)
    `FPCG_ASSERT_NEXT(a_upd_then_mirror, state_reg == ST_REC_UPD, state_reg == ST_REC_MIR)

endmodule

>>> sim/tb_flow_potential_complete_graph.sv
// Testbench for flow_potential_complete_graph: trip records, finish sweeps, zone_count settings.
// Uses fpcg_pkg; results are checked against a behavioral predictor of the net-flow matrix.
module tb_flow_potential_complete_graph
    import fpcg_pkg::*;
();

    localparam int ZONES      = 32;
    localparam int CYCLE_MAX  = 5000000;

    typedef struct {
        logic [ZONE_W-1:0]           zone;
        logic signed [POT_OUT_W-1:0] pot;
        logic [FIT_W-1:0]            fit;
        logic [DEV_W-1:0]            dev;
        logic                        no_flow;
        logic                        last;
    } zone_result_t;

    typedef struct {
        logic               op;
        logic [ZONE_W-1:0]  origin;
        logic [ZONE_W-1:0]  dest;
        logic [COUNT_W-1:0] trips;
        logic               zero_finish;  // expected results typed in: all flows zero
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = OP_RECORD;
    logic [ZONE_W-1:0] s_origin_index = '0;
    logic [ZONE_W-1:0] s_dest_index = '0;
    logic [COUNT_W-1:0] s_trip_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ZONE_W-1:0] m_zone_index;
    logic signed [POT_OUT_W-1:0] m_potential_q16;
    logic [FIT_W-1:0] m_fit_percent_q16;
    logic [DEV_W-1:0] m_null_deviation_q8;
    logic m_no_flow;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_zone_count = '0;

    flow_potential_complete_graph #(.MAX_ZONES(ZONES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_origin_index(s_origin_index), .s_dest_index(s_dest_index),
        .s_trip_count(s_trip_count),
        .m_valid(m_valid), .m_ready(m_ready), .m_zone_index(m_zone_index),
        .m_potential_q16(m_potential_q16), .m_fit_percent_q16(m_fit_percent_q16),
        .m_null_deviation_q8(m_null_deviation_q8), .m_no_flow(m_no_flow), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_zone_count(cfg_zone_count)
    );

    always #2 aclk = ~aclk;

    // predictor state
    int           flow_cell [ZONES][ZONES];
    int           zones_used = ZONES;
    zone_result_t pending_potentials [$];

    int errors = 0;
    int cycles = 0;
    int records_sent = 0;
    int finishes_sent = 0;
    int results_seen = 0;
    int burst_left = 0;

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic void apply_zone_count(logic [CFG_W-1:0] v);
        zones_used = (v < 1) ? 1 : (v > ZONES) ? ZONES : int'(v);
    endfunction

    function automatic void push_zero_finish();
        zone_result_t r;
        for (int i = 0; i < zones_used; i++) begin
            r.zone = ZONE_W'(i);
            r.pot = '0;
            r.fit = '0;
            r.dev = '0;
            r.no_flow = 1'b1;
            r.last = (i == zones_used - 1);
            pending_potentials.push_back(r);
        end
    endfunction

    // apply one accepted item to the matrix; on finish, queue the per-zone potentials
    function automatic void predict_flow(logic op, logic [ZONE_W-1:0] o, logic [ZONE_W-1:0] d,
                                         logic [COUNT_W-1:0] trips, logic push);
        longint       v;
        longint       row_sum [ZONES];
        logic [127:0] sumsq;
        logic [127:0] diffsq;
        logic [159:0] numer, denom, quot, root, cand;
        logic [63:0]  y, m, q;
        logic [FIT_W-1:0] fit;
        logic [DEV_W-1:0] dev;
        logic         none;
        zone_result_t r;
        int           n;
        n = zones_used;
        if (op == OP_RECORD) begin
            if (o < n && d < n && o != d) begin
                v = longint'(flow_cell[o][d]) + longint'(trips);
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                flow_cell[o][d] = int'(v);
                flow_cell[d][o] = int'(-v);
            end
            return;
        end
        sumsq = '0;
        diffsq = '0;
        for (int i = 0; i < n; i++) begin
            row_sum[i] = 0;
            for (int j = 0; j < n; j++) row_sum[i] += longint'(flow_cell[i][j]);
        end
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                y = mag(longint'(flow_cell[i][j]));
                m = mag(row_sum[i] - row_sum[j]);
                sumsq += 128'(y) * 128'(y);
                diffsq += 128'(m) * 128'(m);
            end
        end
        none = (sumsq == 0);
        fit = '0;
        dev = '0;
        if (!none) begin
            numer = 160'(diffsq) * 160'd6553600;
            denom = 160'(sumsq) * 160'(n * n);
            quot = numer / denom;
            fit = (quot > 160'd6553600) ? FIT_MAX : FIT_W'(quot);
            quot = (160'(sumsq) << 17) / 160'(n * n * n);
            root = '0;
            for (int b = 47; b >= 0; b--) begin
                cand = root | (160'd1 << b);
                if (cand * cand <= quot) root = cand;
            end
            dev = root[DEV_W-1:0];
        end
        for (int i = 0; i < n; i++) begin
            m = mag(row_sum[i]) << 16;
            q = (m + 64'(n / 2)) / 64'(n);
            r.zone = ZONE_W'(i);
            r.pot = (row_sum[i] > 0) ? POT_OUT_W'(-q) : POT_OUT_W'(q);
            r.fit = fit;
            r.dev = dev;
            r.no_flow = none;
            r.last = (i == n - 1);
            if (push) pending_potentials.push_back(r);
        end
        for (int i = 0; i < ZONES; i++)
            for (int j = 0; j < ZONES; j++) flow_cell[i][j] = 0;
    endfunction

    // leaves valid high at the accepting edge; the caller decides what follows
    task automatic send_item(logic op, logic [ZONE_W-1:0] o, logic [ZONE_W-1:0] d,
                             logic [COUNT_W-1:0] trips, logic typed_zero);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
        end else begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_origin_index <= o;
        s_dest_index <= d;
        s_trip_count <= trips;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_FINISH) begin
            finishes_sent++;
            if (typed_zero) push_zero_finish();
            predict_flow(op, o, d, trips, !typed_zero);
        end else begin
            records_sent++;
            predict_flow(op, o, d, trips, 1'b0);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_potentials.size() != 0) @(posedge aclk);
        // let the last record's writes land
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_zone_count(logic [CFG_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_zone_count <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_zone_count(v);
    endtask

    task automatic random_record();
        logic [ZONE_W-1:0] o, d;
        // mostly in-range zones so the matrix fills; the rest tests the ignore path
        if ($urandom_range(0, 99) < 85) begin
            o = ZONE_W'($urandom_range(0, zones_used - 1));
            d = ZONE_W'($urandom_range(0, zones_used - 1));
        end else begin
            o = ZONE_W'($urandom);
            d = ZONE_W'($urandom);
        end
        send_item(OP_RECORD, o, d, COUNT_W'($urandom), 1'b0);
    endtask

    // receiver: check each transfer, stall in changing patterns
    int stall_left = 0;
    always @(posedge aclk) begin
        zone_result_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("Some tests failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_potentials.size() == 0) begin
                $error("result for zone %0d with nothing expected", m_zone_index);
                errors++;
            end else begin
                e = pending_potentials.pop_front();
                if (m_zone_index !== e.zone) begin
                    $error("zone_index: expected %0d got %0d", e.zone, m_zone_index);
                    errors++;
                end
                if (m_potential_q16 !== e.pot) begin
                    $error("potential_q16: expected %0d got %0d", e.pot, m_potential_q16);
                    errors++;
                end
                if (m_fit_percent_q16 !== e.fit) begin
                    $error("fit_percent_q16: expected %0d got %0d", e.fit, m_fit_percent_q16);
                    errors++;
                end
                if (m_null_deviation_q8 !== e.dev) begin
                    $error("null_deviation_q8: expected %0d got %0d", e.dev,
                           m_null_deviation_q8);
                    errors++;
                end
                if (m_no_flow !== e.no_flow) begin
                    $error("no_flow: expected %0d got %0d", e.no_flow, m_no_flow);
                    errors++;
                end
                if (m_last !== e.last) begin
                    $error("last: expected %0d got %0d", e.last, m_last);
                    errors++;
                end
            end
        end
        case ((cycles / 500) % 3)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    m_ready <= 1'b0;
                end else begin
                    stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    stim_row_t directed_rows [13] = '{
        '{OP_FINISH, 5'd0,  5'd0,  16'd0,     1'b1},
        '{OP_RECORD, 5'd0,  5'd31, 16'd65535, 1'b0},
        '{OP_RECORD, 5'd31, 5'd0,  16'd0,     1'b0},
        '{OP_RECORD, 5'd5,  5'd5,  16'd65535, 1'b0},
        '{OP_RECORD, 5'd31, 5'd30, 16'd1,     1'b0},
        '{OP_RECORD, 5'd2,  5'd17, 16'd12345, 1'b0},
        '{OP_RECORD, 5'd10, 5'd21, 16'd65535, 1'b0},
        '{OP_FINISH, 5'd31, 5'd31, 16'd65535, 1'b0},
        '{OP_RECORD, 5'd7,  5'd7,  16'd100,   1'b0},
        '{OP_RECORD, 5'd3,  5'd9,  16'd65535, 1'b0},
        '{OP_RECORD, 5'd9,  5'd3,  16'd65535, 1'b0},
        '{OP_RECORD, 5'd12, 5'd12, 16'd0,     1'b0},
        '{OP_FINISH, 5'd0,  5'd0,  16'd0,     1'b1}
    };

    logic [CFG_W-1:0] zone_settings [9] = '{6'd1, 6'd0, 6'd2, 6'd63, 6'd3, 6'd7, 6'd20,
                                            6'd31, 6'd32};

    initial begin
        for (int i = 0; i < ZONES; i++)
            for (int j = 0; j < ZONES; j++) flow_cell[i][j] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_item(directed_rows[k].op, directed_rows[k].origin, directed_rows[k].dest,
                      directed_rows[k].trips, directed_rows[k].zero_finish);

        // a lone record, then a finish at the full zone count
        send_item(OP_RECORD, 5'd4, 5'd6, 16'd777, 1'b0);
        send_item(OP_FINISH, 5'd0, 5'd0, 16'd0, 1'b0);

        foreach (zone_settings[p]) begin
            write_zone_count(zone_settings[p]);
            for (int k = 0; k < 28; k++) begin
                if ($urandom_range(0, 99) < 8)
                    send_item(OP_FINISH, ZONE_W'($urandom), ZONE_W'($urandom),
                              COUNT_W'($urandom), 1'b0);
                else
                    random_record();
            end
            send_item(OP_FINISH, ZONE_W'($urandom), ZONE_W'($urandom), COUNT_W'($urandom),
                      1'b0);
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Covered %0d trip records and %0d finishes over %0d zone_count settings,",
                 records_sent, finishes_sent, $size(zone_settings) + 1);
        $display("with %0d zone results checked.", results_seen);
        if (errors == 0 && pending_potentials.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
